FILE: sv/q2k_pkg.sv
// Shared constants, types and fp16 decode for the Q2_K dot-product engine.
`default_nettype none

package q2k_pkg;

    localparam int SUB_BLOCK_SIZE    = 16;
    localparam int LANE_W            = 16;
    localparam int CODE_W            = 2;
    localparam int TREE_DEPTH        = $clog2(SUB_BLOCK_SIZE);
    localparam int ACT_WIDTH_DEFAULT = 16;
    localparam int NIBBLE_W          = 4;
    localparam int HALF_W            = 16;
    localparam int HALF_MANT_W       = 12;   // signed mantissa incl. hidden bit
    localparam int HALF_SHIFT_W      = 5;
    localparam int HALF_MAX_SHIFT    = 29;   // largest normal exponent minus one
    localparam int SCALED_W          = 16;   // mantissa times 4-bit sub-scale
    localparam int ACC_W             = 64;

    localparam logic [4:0] HALF_EXP_SPECIAL = 5'h1F;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [1:0] {
        HALF_FINITE,
        HALF_INF,
        HALF_NAN
    } half_class_t;

    typedef struct packed {
        half_class_t                    cls;
        logic                           sign;
        logic signed [HALF_MANT_W-1:0]  mant;
        logic [HALF_SHIFT_W-1:0]        shift;
    } half_t;

    // Control that rides along the pipeline with each request.
    typedef struct packed {
        logic valid;
        logic last;
        logic special;      // d or dmin is inf or NaN
        logic special_pos;  // saturate toward the positive extreme
    } pipe_ctrl_t;

    // Finite value = mant * 2^(shift-24).
    function automatic half_t half_decode(input logic [HALF_W-1:0] bits);
        half_t                  h;
        logic [4:0]             e;
        logic [9:0]             m;
        logic [HALF_MANT_W-1:0] mag;
        e      = bits[14:10];
        m      = bits[9:0];
        h.sign = bits[15];
        if (e == HALF_EXP_SPECIAL) begin
            h.cls   = (m != 10'd0) ? HALF_NAN : HALF_INF;
            mag     = '0;
            h.shift = '0;
        end else if (e == 5'd0) begin
            h.cls   = HALF_FINITE;
            mag     = {2'b00, m};
            h.shift = '0;
        end else begin
            h.cls   = HALF_FINITE;
            mag     = {2'b01, m};
            h.shift = e - 5'd1;
        end
        h.mant = h.sign ? -$signed(mag) : $signed(mag);
        return h;
    endfunction

endpackage

`default_nettype wire

FILE: sv/q2k_lane.sv
// One lane: weight code times activation, plus the bare activation.
`default_nettype none

module q2k_lane #(
    parameter int ACT_WIDTH = q2k_pkg::ACT_WIDTH_DEFAULT
) (
    input  wire logic [q2k_pkg::CODE_W-1:0]  code,
    input  wire logic [q2k_pkg::LANE_W-1:0]  lane_act,
    output logic signed [ACT_WIDTH+1:0]      qx,
    output logic signed [ACT_WIDTH-1:0]      x
);

    // only the low ACT_WIDTH bits of the lane carry the activation
    assign x  = $signed(lane_act[ACT_WIDTH-1:0]);
    assign qx = (ACT_WIDTH+2)'(x) * (ACT_WIDTH+2)'($signed({1'b0, code}));

endmodule

`default_nettype wire

FILE: sv/q2k_merge.sv
// Sixteen parallel lanes and the registered adder tree that merges them.
`default_nettype none

module q2k_merge #(
    parameter int ACT_WIDTH = q2k_pkg::ACT_WIDTH_DEFAULT,
    localparam int SQX_W    = ACT_WIDTH + 2 + q2k_pkg::TREE_DEPTH,
    localparam int SX_W     = ACT_WIDTH + q2k_pkg::TREE_DEPTH
) (
    input  wire logic                                                clk,
    input  wire logic                                                en,
    input  wire logic [q2k_pkg::SUB_BLOCK_SIZE*q2k_pkg::CODE_W-1:0]  codes,
    input  wire logic [q2k_pkg::SUB_BLOCK_SIZE*q2k_pkg::LANE_W-1:0]  acts,
    output logic signed [SQX_W-1:0]                                  sqx,
    output logic signed [SX_W-1:0]                                   sx
);

    localparam int N = q2k_pkg::SUB_BLOCK_SIZE;
    localparam int D = q2k_pkg::TREE_DEPTH;

    logic signed [ACT_WIDTH+1:0] lane_qx [N];
    logic signed [ACT_WIDTH-1:0] lane_x  [N];
    logic signed [SQX_W-1:0]     qx_lvl  [D+1][N];
    logic signed [SX_W-1:0]      x_lvl   [D+1][N];
    logic signed [SQX_W-1:0]     sqx_reg;
    logic signed [SX_W-1:0]      sx_reg;

    for (genvar l = 0; l < N; l++) begin : g_lane
        q2k_lane #(
            .ACT_WIDTH (ACT_WIDTH)
        ) u_lane (
            .code     (codes[l*q2k_pkg::CODE_W +: q2k_pkg::CODE_W]),
            .lane_act (acts[l*q2k_pkg::LANE_W +: q2k_pkg::LANE_W]),
            .qx       (lane_qx[l]),
            .x        (lane_x[l])
        );
    end

    // balanced pairwise tree, log2(N) adder levels
    always_comb
    begin
        for (int lv = 0; lv <= D; lv++)
        begin
            for (int i = 0; i < N; i++)
            begin
                qx_lvl[lv][i] = '0;
                x_lvl[lv][i]  = '0;
            end
        end
        for (int i = 0; i < N; i++)
        begin
            qx_lvl[0][i] = SQX_W'(lane_qx[i]);
            x_lvl[0][i]  = SX_W'(lane_x[i]);
        end
        for (int lv = 1; lv <= D; lv++)
        begin
            for (int i = 0; i < (N >> lv); i++)
            begin
                qx_lvl[lv][i] = qx_lvl[lv-1][2*i] + qx_lvl[lv-1][2*i+1];
                x_lvl[lv][i]  = x_lvl[lv-1][2*i] + x_lvl[lv-1][2*i+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= qx_lvl[D][0];
            sx_reg  <= x_lvl[D][0];
        end
    end

    assign sqx = sqx_reg;
    assign sx  = sx_reg;

endmodule

`default_nettype wire

FILE: sv/q2k_accum.sv
// Row accumulator with saturation and the result register.
`default_nettype none

module q2k_accum #(
    parameter int DIFF_W = 68
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire q2k_pkg::pipe_ctrl_t                ctrl,
    input  wire logic signed [DIFF_W-1:0]           diff,
    input  wire logic                               res_stall,
    output logic                                    res_valid,
    output logic signed [q2k_pkg::ACC_W-1:0]        row_sum,
    output logic                                    saturated
);

    localparam int ACC_W = q2k_pkg::ACC_W;
    localparam int SUM_W = ((DIFF_W > ACC_W) ? DIFF_W : ACC_W) + 1;

    logic signed [ACC_W-1:0] acc_reg, acc_next, acc_new;
    logic                    sat_reg, sat_next, sat_new;
    logic                    res_valid_reg, res_valid_next;
    logic signed [ACC_W-1:0] row_sum_reg, row_sum_next;
    logic                    saturated_reg, saturated_next;
    logic signed [SUM_W-1:0] total;
    logic                    fits;

    assign total = SUM_W'(acc_reg) + SUM_W'(diff);
    assign fits  = (total[SUM_W-1:ACC_W-1] == '0) || (total[SUM_W-1:ACC_W-1] == '1);

    always_comb
    begin
        // sticky: a saturated row ignores the rest of its requests
        if (sat_reg)
        begin
            acc_new = acc_reg;
            sat_new = 1'b1;
        end else if (ctrl.special)
        begin
            acc_new = ctrl.special_pos ? q2k_pkg::ACC_MAX : q2k_pkg::ACC_MIN;
            sat_new = 1'b1;
        end else if (fits)
        begin
            acc_new = total[ACC_W-1:0];
            sat_new = 1'b0;
        end else
        begin
            acc_new = total[SUM_W-1] ? q2k_pkg::ACC_MIN : q2k_pkg::ACC_MAX;
            sat_new = 1'b1;
        end

        acc_next       = acc_reg;
        sat_next       = sat_reg;
        row_sum_next   = row_sum_reg;
        saturated_next = saturated_reg;
        res_valid_next = res_valid_reg && res_stall;
        if (en && ctrl.valid)
        begin
            if (ctrl.last)
            begin
                row_sum_next   = acc_new;
                saturated_next = sat_new;
                res_valid_next = 1'b1;
                acc_next       = '0;
                sat_next       = 1'b0;
            end else
            begin
                acc_next = acc_new;
                sat_next = sat_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            sat_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end else
        begin
            acc_reg       <= acc_next;
            sat_reg       <= sat_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_sum_reg   <= row_sum_next;
        saturated_reg <= saturated_next;
    end

    assign res_valid = res_valid_reg;
    assign row_sum   = row_sum_reg;
    assign saturated = saturated_reg;

endmodule

`default_nettype wire

FILE: sv/q2k_block_dot_product.sv
// Top level of the Q2_K sub-block dot-product engine.
//
// Each request carries one 16-weight sub-block: sixteen unpacked 2-bit codes,
// sixteen signed activations (low ACT_WIDTH bits of each 16-bit lane), the
// scale byte and the fp16 super-scales d and dmin. The engine adds
// d*(scale&15)*sum(q*x) - dmin*(scale>>4)*sum(x) into a 64-bit row
// accumulator with 24 fractional bits, exact for every finite fp16. Overflow,
// an infinite d or dmin, or a NaN saturates the row (sticky until the row
// ends) and raises saturated. The row sum is presented once, on the request
// marked last_in_row, and the accumulator then starts the next row from zero.
// Throughput is one request per clock while req_stall is low. The datapath
// is a five-register pipeline: input register, sixteen parallel lanes merged
// by an adder tree (fp16 decode and sub-scale multiply alongside), the two
// scale multipliers, the exponent shift and combine, and the accumulator.
// res_valid rises when the accumulator takes the last request of a row. req_stall is
// raised only when a row result is still unread and the next row end has
// reached the accumulator; the whole pipeline then holds.
`default_nettype none

module q2k_block_dot_product #(
    parameter int ACT_WIDTH = q2k_pkg::ACT_WIDTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request channel
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic [31:0]                   codes,
    input  wire logic [63:0]                   acts_0_3,
    input  wire logic [63:0]                   acts_4_7,
    input  wire logic [63:0]                   acts_8_11,
    input  wire logic [63:0]                   acts_12_15,
    input  wire logic [7:0]                    sub_scale,
    input  wire logic [15:0]                   super_scale_bits,
    input  wire logic [15:0]                   super_min_bits,
    input  wire logic                          last_in_row,
    // result channel
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output logic signed [q2k_pkg::ACC_W-1:0]   row_sum,
    output logic                               saturated
);

    localparam int SQX_W  = ACT_WIDTH + 2 + q2k_pkg::TREE_DEPTH;
    localparam int SX_W   = ACT_WIDTH + q2k_pkg::TREE_DEPTH;
    localparam int PD_W   = q2k_pkg::SCALED_W + SQX_W;
    localparam int PM_W   = q2k_pkg::SCALED_W + SX_W;
    localparam int DIFF_W = PD_W + q2k_pkg::HALF_MAX_SHIFT + 1;
    localparam int SH_W   = q2k_pkg::HALF_SHIFT_W;
    localparam int SC_W   = q2k_pkg::SCALED_W;
    localparam int NIB_W  = q2k_pkg::NIBBLE_W;

    // pipeline advances unless a finished row would overwrite an unread one
    logic en;

    // stage A: captured request
    logic                           a_valid_reg;
    logic                           a_last_reg;
    logic [31:0]                    a_codes_reg;
    logic [255:0]                   a_acts_reg;
    logic [7:0]                     a_sc_reg;
    logic [15:0]                    a_dbits_reg;
    logic [15:0]                    a_mbits_reg;

    // stage B: lane sums, decoded scales
    q2k_pkg::half_t                 dec_d, dec_m;
    q2k_pkg::pipe_ctrl_t            b_ctrl_next;
    logic                           d_inf, m_inf, any_nan, conflict, dir_pos;
    logic signed [SC_W-1:0]         scaled_d_next, scaled_m_next;
    q2k_pkg::pipe_ctrl_t            b_ctrl_reg;
    logic signed [SC_W-1:0]         b_scaled_d_reg, b_scaled_m_reg;
    logic [SH_W-1:0]                b_shd_reg, b_shm_reg;
    logic signed [SQX_W-1:0]        b_sqx;
    logic signed [SX_W-1:0]         b_sx;

    // stage C: scale products
    q2k_pkg::pipe_ctrl_t            c_ctrl_reg;
    logic signed [PD_W-1:0]         c_prod_d_reg;
    logic signed [PM_W-1:0]         c_prod_m_reg;
    logic [SH_W-1:0]                c_shd_reg, c_shm_reg;

    // stage D: exponent-aligned difference
    logic signed [DIFF_W-1:0]       term_d, term_m;
    q2k_pkg::pipe_ctrl_t            d_ctrl_reg;
    logic signed [DIFF_W-1:0]       d_diff_reg;

    assign en        = !(res_valid && res_stall && d_ctrl_reg.valid && d_ctrl_reg.last);
    assign req_stall = !en;

    // ---------------- stage A ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end else if (en)
        begin
            a_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_last_reg  <= last_in_row;
            a_codes_reg <= codes;
            a_acts_reg  <= {acts_12_15, acts_8_11, acts_4_7, acts_0_3};
            a_sc_reg    <= sub_scale;
            a_dbits_reg <= super_scale_bits;
            a_mbits_reg <= super_min_bits;
        end
    end

    // ---------------- stage B ----------------
    q2k_merge #(
        .ACT_WIDTH (ACT_WIDTH)
    ) u_merge (
        .clk   (clk),
        .en    (en),
        .codes (a_codes_reg),
        .acts  (a_acts_reg),
        .sqx   (b_sqx),
        .sx    (b_sx)
    );

    // Inf d pushes toward sign(d), inf dmin toward -sign(dmin); opposing
    // infinities behave like NaN and go to the positive extreme.
    always_comb
    begin
        dec_d    = q2k_pkg::half_decode(a_dbits_reg);
        dec_m    = q2k_pkg::half_decode(a_mbits_reg);
        d_inf    = (dec_d.cls == q2k_pkg::HALF_INF);
        m_inf    = (dec_m.cls == q2k_pkg::HALF_INF);
        conflict = d_inf && m_inf && (dec_d.sign == dec_m.sign);
        any_nan  = (dec_d.cls == q2k_pkg::HALF_NAN) || (dec_m.cls == q2k_pkg::HALF_NAN)
                   || conflict;
        dir_pos  = m_inf ? dec_m.sign : !dec_d.sign;

        b_ctrl_next.valid       = a_valid_reg;
        b_ctrl_next.last        = a_last_reg;
        b_ctrl_next.special     = (dec_d.cls != q2k_pkg::HALF_FINITE)
                                  || (dec_m.cls != q2k_pkg::HALF_FINITE);
        b_ctrl_next.special_pos = any_nan || dir_pos;

        scaled_d_next = SC_W'(dec_d.mant) * SC_W'($signed({1'b0, a_sc_reg[NIB_W-1:0]}));
        scaled_m_next = SC_W'(dec_m.mant) * SC_W'($signed({1'b0, a_sc_reg[7:NIB_W]}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_ctrl_reg <= '0;
        end else if (en)
        begin
            b_ctrl_reg <= b_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_scaled_d_reg <= scaled_d_next;
            b_scaled_m_reg <= scaled_m_next;
            b_shd_reg      <= dec_d.shift;
            b_shm_reg      <= dec_m.shift;
        end
    end

    // ---------------- stage C ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_ctrl_reg <= '0;
        end else if (en)
        begin
            c_ctrl_reg <= b_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_prod_d_reg <= PD_W'(b_scaled_d_reg) * PD_W'(b_sqx);
            c_prod_m_reg <= PM_W'(b_scaled_m_reg) * PM_W'(b_sx);
            c_shd_reg    <= b_shd_reg;
            c_shm_reg    <= b_shm_reg;
        end
    end

    // ---------------- stage D ----------------
    assign term_d = DIFF_W'(c_prod_d_reg) <<< c_shd_reg;
    assign term_m = DIFF_W'(c_prod_m_reg) <<< c_shm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_ctrl_reg <= '0;
        end else if (en)
        begin
            d_ctrl_reg <= c_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_diff_reg <= term_d - term_m;
        end
    end

    // ---------------- accumulator and result ----------------
    q2k_accum #(
        .DIFF_W (DIFF_W)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctrl      (d_ctrl_reg),
        .diff      (d_diff_reg),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .row_sum   (row_sum),
        .saturated (saturated)
    );

    // ---------------- assertions ----------------
    // a new result only follows a row end leaving the last stage
    a_result_from_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(d_ctrl_reg.valid && d_ctrl_reg.last))
        else $error("result appeared without a row end");

    // requests are held back only behind an unread result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (res_valid && res_stall))
        else $error("request stalled without a blocked result");

    // a saturated row always reports one of the extremes
    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && saturated) |->
            ((row_sum == q2k_pkg::ACC_MAX) || (row_sum == q2k_pkg::ACC_MIN)))
        else $error("saturated row sum is not an extreme");

endmodule

`default_nettype wire
